/* sv/oli_pkg.sv */
// ----------------------------------------------------------------------------
// oli_pkg
// Shared codes, field widths and types of the positional ordered list.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 7;
  localparam int VALUE_W    = 32;
  localparam int REMOVED_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OPCODE_W-1:0] OP_INSERT_AT    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE_AT    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD_FRONT    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ADD_REAR     = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DELETE_FRONT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DELETE_REAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic ins;
    logic del;
  } shift_t;

endpackage

/* sv/oli_cell.sv */
// ----------------------------------------------------------------------------
// oli_cell
// One list slot: holds an element and shifts it to or from its neighbors.
// ----------------------------------------------------------------------------
module oli_cell #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  oli_pkg::shift_t               ctl,
  input  logic [$clog2(CAPACITY)-1:0]   sel_idx,
  input  logic [DATA_WIDTH-1:0]         wdata,
  input  logic [DATA_WIDTH-1:0]         left_data,
  input  logic [DATA_WIDTH-1:0]         right_data,
  output logic [DATA_WIDTH-1:0]         data_o,
  output logic [DATA_WIDTH-1:0]         tap_o
);
  import oli_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] tap_r;
  logic                  above;
  logic                  hit;

  assign above = MY_IDX > sel_idx;
  assign hit   = MY_IDX == sel_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl.ins) begin
        if (above) begin
          data_r <= left_data;
        end else if (hit) begin
          data_r <= wdata;
        end
      end else if (ctl.del) begin
        if (above || hit) begin
          data_r <= right_data;
        end
      end
      tap_r <= (ctl.del && hit) ? data_r : '0;
    end
  end

  assign data_o = data_r;
  assign tap_o  = tap_r;

endmodule

/* sv/oli_ctrl.sv */
// ----------------------------------------------------------------------------
// oli_ctrl
// Opcode decode, range and fill checks, element count register.
// ----------------------------------------------------------------------------
module oli_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [oli_pkg::OPCODE_W-1:0]       opcode,
  input  logic [oli_pkg::POSITION_W-1:0]     position,
  output oli_pkg::shift_t                    ctl,
  output logic [$clog2(CAPACITY)-1:0]        idx,
  output logic [oli_pkg::STATUS_W-1:0]       status,
  output logic [$clog2(CAPACITY+1)-1:0]      count_nxt
);
  import oli_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
  localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);
  localparam logic [PW-1:0] ONE   = PW'(1);

  logic [CW-1:0] count_r;
  logic [PW-1:0] pos_e;
  logic [PW-1:0] cnt_e;
  logic [PW-1:0] idx_w;
  logic          full;
  logic          empty;

  assign pos_e = PW'(position);
  assign cnt_e = PW'(count_r);
  assign full  = cnt_e == CAP_V;
  assign empty = cnt_e == '0;

  always_comb begin
    ctl    = '0;
    idx_w  = '0;
    status = ST_OK;
    case (opcode)
      OP_INSERT_AT: begin
        if (pos_e == '0 || pos_e > cnt_e + ONE) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          idx_w   = pos_e - ONE;
        end
      end
      OP_DELETE_AT: begin
        if (pos_e == '0 || pos_e > cnt_e) begin
          status = ST_RANGE;
        end else begin
          ctl.del = 1'b1;
          idx_w   = pos_e - ONE;
        end
      end
      OP_ADD_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      OP_ADD_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
          idx_w   = cnt_e;
        end
      end
      OP_DELETE_FRONT: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          ctl.del = 1'b1;
        end
      end
      OP_DELETE_REAR: begin
        if (empty) begin
          status = ST_UNDER;
        end else begin
          ctl.del = 1'b1;
          idx_w   = cnt_e - ONE;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign idx = idx_w[IW-1:0];

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (en) begin
      count_r <= count_nxt;
    end
  end

endmodule

/* sv/ordered_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Bounded list of values addressed by 1-based position, held in a shift chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one operation per transfer (opcode, position, value).
//   Output stream out_*: exactly one result per operation, in order
//   (removed value, status, element count after the operation).
//   Every slot is its own cell; an insert shifts the cells behind the target
//   up by one and a delete shifts them down, all in the accepting cycle, so
//   the next operation may follow in the next cycle unless the output
//   stalls: one item per cycle. The cells and the removal taps update at
//   the accepting edge; the taps of all cells are OR-combined into the
//   output register as the result leaves the pending stage.
//   One result waits in a pending stage and one in the output register; while
//   out_tready is low the pending stage fills and in_tready drops.
//   Reset empties the list (count zero); element contents are not cleared,
//   only held elements are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // opcode[2:0], position[9:3], value[41:10], zero[47:42]
  input  logic [oli_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // removed_value[31:0], status[33:32], item_count[40:34], zero[47:41]
  output logic [oli_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import oli_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > COUNT_W) ? CW : COUNT_W);

  logic [OPCODE_W-1:0]   in_opcode;
  logic [POSITION_W-1:0] in_position;
  logic [VALUE_W-1:0]    in_value;
  logic                  accept;
  logic                  pend_go;

  shift_t                ctl;
  logic [IW-1:0]         idx;
  logic [STATUS_W-1:0]   status;
  logic [CW-1:0]         count_nxt;
  logic [XW-1:0]         count_ext;

  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] tap    [CAPACITY];
  logic [CAPACITY-1:0]   tap_col [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] removed;
  logic [REMOVED_W-1:0]  removed_out;

  logic                  pend_r;
  logic [STATUS_W-1:0]   pend_status_r;
  logic [COUNT_W-1:0]    pend_count_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign in_opcode   = in_tdata[OPCODE_W-1:0];
  assign in_position = in_tdata[OPCODE_W+POSITION_W-1:OPCODE_W];
  assign in_value    = in_tdata[OPCODE_W+POSITION_W+VALUE_W-1:OPCODE_W+POSITION_W];

  assign pend_go   = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || pend_go;
  assign accept    = in_tvalid && in_tready;

  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_win_narrow
      assign wdata = in_value[DATA_WIDTH-1:0];
    end else begin : g_win_wide
      assign wdata = {{(DATA_WIDTH-VALUE_W){1'b0}}, in_value};
    end
  endgenerate

  oli_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .opcode    (in_opcode),
    .position  (in_position),
    .ctl       (ctl),
    .idx       (idx),
    .status    (status),
    .count_nxt (count_nxt)
  );

  genvar i, b;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_chain
      logic [DATA_WIDTH-1:0] left_d;
      logic [DATA_WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_left
        assign left_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_right
        assign right_d = cell_q[i+1];
      end
      oli_cell #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .IDX        (i)
      ) u_cell (
        .clk        (clk),
        .en         (accept),
        .ctl        (ctl),
        .sel_idx    (idx),
        .wdata      (wdata),
        .left_data  (left_d),
        .right_data (right_d),
        .data_o     (cell_q[i]),
        .tap_o      (tap[i])
      );
      for (b = 0; b < DATA_WIDTH; b++) begin : g_col
        assign tap_col[b][i] = tap[i][b];
      end
    end
    for (b = 0; b < DATA_WIDTH; b++) begin : g_or
      assign removed[b] = |tap_col[b];
    end
    if (DATA_WIDTH >= REMOVED_W) begin : g_rout_wide
      assign removed_out = removed[REMOVED_W-1:0];
    end else begin : g_rout_narrow
      assign removed_out = {{(REMOVED_W-DATA_WIDTH){1'b0}}, removed};
    end
  endgenerate

  assign count_ext = XW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (accept) begin
      pend_r <= 1'b1;
    end else if (pend_go) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r <= status;
      pend_count_r  <= count_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_go) begin
      out_data_r <= {{(OUT_TDATA_W-REMOVED_W-STATUS_W-COUNT_W){1'b0}},
                     pend_count_r, pend_status_r, removed_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* bench/ordered_list_insert_delete_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_tb
// Drives list operations into the positional list and checks every result
// against a queue-based model of the list: removed value, status and count.
// A directed pass covers empty, bad-position and unused-opcode cases; random
// phases then grow the list to full, drain it to empty and mix the two.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_tb;
  import oli_pkg::*;

  localparam int LIST_DEPTH    = 64;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int PHASE_ITEMS   = 130;
  localparam int MAX_GAP       = 14;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} mix_mode_t;

  typedef struct packed {
    logic [REMOVED_W-1:0] removed_value;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   item_count;
  } list_result_t;

  class list_tracker;
    logic [VALUE_W-1:0] cells[$];
    list_result_t       expected_results[$];
    int                 errors;

    function int count();
      return cells.size();
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_op(logic [OPCODE_W-1:0] op, logic [POSITION_W-1:0] pos,
                          logic [VALUE_W-1:0] val);
      list_result_t r;
      int           n;
      int           p;
      n = cells.size();
      p = int'(pos);
      r.removed_value = '0;
      r.status        = ST_OK;
      case (op)
        OP_INSERT_AT: begin
          if (p < 1 || p > n + 1) r.status = ST_RANGE;
          else if (n >= LIST_DEPTH) r.status = ST_FULL;
          else cells.insert(p - 1, val);
        end
        OP_DELETE_AT: begin
          if (p < 1 || p > n) begin
            r.status = ST_RANGE;
          end else begin
            r.removed_value = cells[p - 1];
            cells.delete(p - 1);
          end
        end
        OP_ADD_FRONT: begin
          if (n >= LIST_DEPTH) r.status = ST_FULL;
          else cells.push_front(val);
        end
        OP_ADD_REAR: begin
          if (n >= LIST_DEPTH) r.status = ST_FULL;
          else cells.push_back(val);
        end
        OP_DELETE_FRONT: begin
          if (n == 0) r.status = ST_UNDER;
          else r.removed_value = cells.pop_front();
        end
        OP_DELETE_REAR: begin
          if (n == 0) r.status = ST_UNDER;
          else r.removed_value = cells.pop_back();
        end
        default: ;
      endcase
      r.item_count = COUNT_W'(cells.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      list_result_t want;
      list_result_t got;
      got.removed_value = tdata[31:0];
      got.status        = tdata[33:32];
      got.item_count    = tdata[40:34];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, tdata);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.removed_value !== want.removed_value) begin
        $display("%0t: removed_value expected %h, got %h", $time,
                 want.removed_value, got.removed_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.item_count !== want.item_count) begin
        $display("%0t: item_count expected %0d, got %0d", $time,
                 want.item_count, got.item_count);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  list_tracker tracker;
  bit          calm;
  int          idle_cycles;

  ordered_list_insert_delete #(
    .CAPACITY  (LIST_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(MAX_GAP));
  endfunction

  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [POSITION_W-1:0] pos,
                         input logic [VALUE_W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    tracker.note_op(op, pos, val);
  endtask

  task automatic send_random(input mix_mode_t mode);
    int                    n;
    int                    roll;
    int                    grow_pct;
    logic [OPCODE_W-1:0]   op;
    logic [POSITION_W-1:0] pos;
    n = tracker.count();
    roll = $urandom_range(99);
    case (mode)
      MODE_GROW:   grow_pct = 78;
      MODE_SHRINK: grow_pct = 25;
      default:     grow_pct = 52;
    endcase
    if (roll < 3) begin
      op = ($urandom_range(1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
    end else if (roll < grow_pct) begin
      case ($urandom_range(2))
        0:       op = OP_INSERT_AT;
        1:       op = OP_ADD_FRONT;
        default: op = OP_ADD_REAR;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       op = OP_DELETE_AT;
        1:       op = OP_DELETE_FRONT;
        default: op = OP_DELETE_REAR;
      endcase
    end
    if (op == OP_INSERT_AT && $urandom_range(9) > 0)
      pos = POSITION_W'($urandom_range(n + 1, 1));
    else if (op == OP_DELETE_AT && n > 0 && $urandom_range(9) > 0)
      pos = POSITION_W'($urandom_range(n, 1));
    else
      pos = POSITION_W'($urandom_range(127));
    send_op(op, pos, $urandom);
  endtask

  task automatic wait_results_done();
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  // result side: random stalls, one transfer at a time
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("ordered_list_insert_delete: mismatch");
    $finish;
  end

  initial begin
    mix_mode_t mode;
    tracker     = new();
    calm        = 1'b0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, bad positions, ends, unused opcodes
    send_op(OP_DELETE_FRONT, 7'd0,   32'h1234_5678);
    send_op(OP_DELETE_REAR,  7'd0,   32'h0);
    send_op(OP_DELETE_AT,    7'd1,   32'h0);
    send_op(OP_INSERT_AT,    7'd0,   32'hDEAD_BEEF);
    send_op(OP_INSERT_AT,    7'd2,   32'hDEAD_BEEF);
    send_op(OP_INSERT_AT,    7'd1,   32'h0000_0000);
    send_op(OP_ADD_FRONT,    7'd127, 32'hFFFF_FFFF);
    send_op(OP_ADD_REAR,     7'd0,   32'hA5A5_5A5A);
    send_op(OP_INSERT_AT,    7'd4,   32'h0000_0001);
    send_op(OP_INSERT_AT,    7'd2,   32'h8000_0000);
    send_op(OP_INSERT_AT,    7'd127, 32'h7FFF_FFFF);
    send_op(OP_DELETE_AT,    7'd127, 32'h0);
    send_op(OP_DELETE_AT,    7'd0,   32'h0);
    send_op(OP_UNUSED_6,     7'd127, 32'hFFFF_FFFF);
    send_op(OP_UNUSED_7,     7'd1,   32'h0);
    send_op(OP_DELETE_AT,    7'd3,   32'h0);
    send_op(OP_DELETE_FRONT, 7'd0,   32'h0);
    send_op(OP_DELETE_REAR,  7'd0,   32'h0);
    send_op(OP_DELETE_AT,    7'd2,   32'h0);
    send_op(OP_DELETE_AT,    7'd1,   32'h0);
    send_op(OP_ADD_REAR,     7'd0,   32'h5555_AAAA);
    send_op(OP_DELETE_REAR,  7'd0,   32'h0);

    in_tvalid <= 1'b0;
    wait_results_done();

    // grow to full, drain to empty, then mixed phases
    for (int i = 0; i < RANDOM_ITEMS / PHASE_ITEMS; i++) begin
      case (i % 3)
        0:       mode = MODE_GROW;
        1:       mode = MODE_SHRINK;
        default: mode = MODE_MIX;
      endcase
      calm = ($urandom_range(3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) send_random(mode);
      if (i == 0 || $urandom_range(1) == 0) begin
        in_tvalid <= 1'b0;
        wait_results_done();
      end
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("ordered_list_insert_delete: match");
    else
      $display("ordered_list_insert_delete: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
sv/oli_pkg.sv
sv/oli_cell.sv
sv/oli_ctrl.sv
sv/ordered_list_insert_delete.sv
bench/ordered_list_insert_delete_tb.sv
